FILE: rtl/core/sprite_viewport_cull_unit_assert.svh
// Assertion macros shared by the sprite viewport cull unit.
`ifndef SPRITE_VIEWPORT_CULL_UNIT_ASSERT_SVH
`define SPRITE_VIEWPORT_CULL_UNIT_ASSERT_SVH

// Clocked assertion on clk, switched off while rst_n is low.
`define SVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check written as an implication from a condition to a same-cycle consequence.
`define SVC_ASSERT_IMPL(label, ante, cons, msg) \
    `SVC_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/svc_pkg.sv
// Package with widths, field offsets, register indexes and stage types of the cull unit.
package svc_pkg;

    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 10;
    localparam int HALF_BITS  = 16;
    localparam int TAG_BITS   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Scroll times factor: signed 16 by signed 11 bits.
    localparam int SCR_W  = HALF_BITS + FRAC_BITS + 1;
    // Size times origin fraction, unsigned.
    localparam int ANC_W  = COORD_BITS + FRAC_BITS;
    // Object corner in Q.12: three terms summed, then the size added for the far corner.
    localparam int OXW    = (((COORD_BITS + 11) > (SCR_W + 4)) ?
                             (COORD_BITS + 11) : (SCR_W + 4)) + 2;
    localparam int OW     = OXW + 1;
    // Corner times coefficient.
    localparam int PRW    = OW + HALF_BITS;
    // Mapped corner in Q.20, wide enough for the viewport bounds as well.
    localparam int TW     = (((PRW + 1) > 37) ? (PRW + 1) : 37) + 1;
    localparam int SHIFT_Q20 = 20;

    // Input tdata layout, lowest bits first.
    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + COORD_BITS;
    localparam int SIZE_W_LSB = POS_Y_LSB + COORD_BITS;
    localparam int SIZE_H_LSB = SIZE_W_LSB + COORD_BITS;
    localparam int ANC_X_LSB  = SIZE_H_LSB + COORD_BITS;
    localparam int ANC_Y_LSB  = ANC_X_LSB + FRAC_BITS;
    localparam int PAR_X_LSB  = ANC_Y_LSB + FRAC_BITS;
    localparam int PAR_Y_LSB  = PAR_X_LSB + FRAC_BITS;
    localparam int TAG_LSB    = PAR_Y_LSB + FRAC_BITS;
    localparam int IN_USED_W  = TAG_LSB + TAG_BITS;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Input tuser layout.
    localparam int IN_USER_W       = 2;
    localparam int USER_HAS_SIZE   = 0;
    localparam int USER_IN_CONTAIN = 1;

    // Output tdata layout.
    localparam int KEEP_BIT    = TAG_BITS;
    localparam int OUT_USED_W  = TAG_BITS + 1;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_COEFFS = 3'd0,
        REG_TRANSLATION   = 3'd1,
        REG_VIEW_POSITION = 3'd2,
        REG_VIEW_SIZE     = 3'd3,
        REG_SCROLL        = 3'd4,
        REG_CULL_DISABLE  = 3'd5
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] LINEAR_COEFFS_RESET = 64'h0000_0000_0100_0100;

    typedef struct packed {
        logic                  bypass;
        logic [TAG_BITS-1:0]   tag;
        logic                  last;
    } side_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0]        w;
        logic [COORD_BITS-1:0]        h;
        logic signed [SCR_W-1:0]      scr_x;
        logic signed [SCR_W-1:0]      scr_y;
        logic [ANC_W-1:0]             anc_x;
        logic [ANC_W-1:0]             anc_y;
        side_t                        side;
    } s1_t;

    typedef struct packed {
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
        logic signed [OW-1:0] ox2;
        logic signed [OW-1:0] oy2;
        side_t                side;
    } s2_t;

    typedef struct packed {
        logic signed [PRW-1:0] ox_a;
        logic signed [PRW-1:0] oy_c;
        logic signed [PRW-1:0] ox_b;
        logic signed [PRW-1:0] oy_d;
        logic signed [PRW-1:0] ox2_a;
        logic signed [PRW-1:0] oy2_c;
        logic signed [PRW-1:0] ox2_b;
        logic signed [PRW-1:0] oy2_d;
        side_t                 side;
    } s3_t;

    typedef struct packed {
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [TW-1:0] tw;
        logic signed [TW-1:0] th;
        side_t                side;
    } s4_t;

endpackage

FILE: rtl/core/sprite_viewport_cull_unit.sv
// Top level of the sprite viewport cull unit: a five-stage pipelined keep/cull judge.
// Throughput: one object per cycle while m_axis_tready is high; the five register stages
// each hold one object, and the corner-times-coefficient multiplier stage sets the depth of the slowest stage.
// Reset (rst_n, asynchronous, active low) empties every stage and loads the register
// reset values (a and b at one, c and d at zero, so the matrix starts singular and every
// object passes; all else zero); no memory needs clearing afterwards.
module sprite_viewport_cull_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [svc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Object stream in.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: pos_x, pos_y, size_w, size_h, anchor_x, anchor_y,
    // parallax_x, parallax_y, object_tag, zero fill.
    input  logic [svc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0 up: has_size, in_container.
    input  logic [svc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  logic                              s_axis_tlast,
    // Verdict stream out.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0 up: tag_out, keep, zero fill.
    output logic [svc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import svc_pkg::*;

    localparam int CB = COORD_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back; writes to an
    // index past the register list are dropped.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] linear_coeffs_reg;
    logic [31:0]           translation_reg;
    logic [31:0]           view_position_reg;
    logic [31:0]           view_size_reg;
    logic [31:0]           scroll_reg;
    logic                  cull_disable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_coeffs_reg <= LINEAR_COEFFS_RESET;
            translation_reg   <= '0;
            view_position_reg <= '0;
            view_size_reg     <= '0;
            scroll_reg        <= '0;
            cull_disable_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LINEAR_COEFFS: linear_coeffs_reg <= cfg_data;
                REG_TRANSLATION:   translation_reg   <= cfg_data[31:0];
                REG_VIEW_POSITION: view_position_reg <= cfg_data[31:0];
                REG_VIEW_SIZE:     view_size_reg     <= cfg_data[31:0];
                REG_SCROLL:        scroll_reg        <= cfg_data[31:0];
                REG_CULL_DISABLE:  cull_disable_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Matrix coefficients and the other register halves as signed numbers.
    logic signed [HALF_BITS-1:0] ma, mb, mc, md, me, mf;
    logic signed [HALF_BITS-1:0] scroll_x, scroll_y, view_left, view_top;
    logic [HALF_BITS-1:0]        view_w, view_h;

    assign ma        = $signed(linear_coeffs_reg[15:0]);
    assign mb        = $signed(linear_coeffs_reg[31:16]);
    assign mc        = $signed(linear_coeffs_reg[47:32]);
    assign md        = $signed(linear_coeffs_reg[63:48]);
    assign me        = $signed(translation_reg[15:0]);
    assign mf        = $signed(translation_reg[31:16]);
    assign scroll_x  = $signed(scroll_reg[15:0]);
    assign scroll_y  = $signed(scroll_reg[31:16]);
    assign view_left = $signed(view_position_reg[15:0]);
    assign view_top  = $signed(view_position_reg[31:16]);
    assign view_w    = view_size_reg[15:0];
    assign view_h    = view_size_reg[31:16];

    // The determinant test depends on configuration only. It is formed in two register steps, which
    // settle well before any object reaches the last stage provided configuration changes only while
    // the pipeline is empty; the user must keep to this, as the block itself does not enforce it.
    logic signed [2*HALF_BITS-1:0] det_ad_reg, det_bc_reg;
    logic                          det_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_ad_reg <= '0;
            det_bc_reg <= '0;
            det_nz_reg <= 1'b0;
        end
        else
        begin
            det_ad_reg <= ma * md;
            det_bc_reg <= mb * mc;
            det_nz_reg <= (det_ad_reg != det_bc_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Each stage takes new data when it is empty or when the
    // stage after it is taking its data, so bubbles are squeezed out and a
    // waiting result does not block the inputs until every stage is full.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic ld1, ld2, ld3, ld4, ld_out;

    assign ld_out        = !out_v_reg || m_axis_tready;
    assign ld4           = !v4_reg || ld_out;
    assign ld3           = !v3_reg || ld4;
    assign ld2           = !v2_reg || ld3;
    assign ld1           = !v1_reg || ld2;
    assign s_axis_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                out_v_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, scroll times scroll factor, size times origin.
    // Objects without a size, inside a container, or seen while culling is
    // off are marked to pass; they still flow through every stage in order.
    // ------------------------------------------------------------------
    s1_t s1_reg, s1_next;
    logic [FRAC_BITS-1:0] in_par_x, in_par_y, in_anc_x, in_anc_y;

    assign in_anc_x = s_axis_tdata[ANC_X_LSB +: FRAC_BITS];
    assign in_anc_y = s_axis_tdata[ANC_Y_LSB +: FRAC_BITS];
    assign in_par_x = s_axis_tdata[PAR_X_LSB +: FRAC_BITS];
    assign in_par_y = s_axis_tdata[PAR_Y_LSB +: FRAC_BITS];

    always_comb
    begin
        s1_next.px          = $signed(s_axis_tdata[POS_X_LSB +: CB]);
        s1_next.py          = $signed(s_axis_tdata[POS_Y_LSB +: CB]);
        s1_next.w           = s_axis_tdata[SIZE_W_LSB +: CB];
        s1_next.h           = s_axis_tdata[SIZE_H_LSB +: CB];
        s1_next.scr_x       = scroll_x * $signed({1'b0, in_par_x});
        s1_next.scr_y       = scroll_y * $signed({1'b0, in_par_y});
        s1_next.anc_x       = s1_next.w * in_anc_x;
        s1_next.anc_y       = s1_next.h * in_anc_y;
        s1_next.side.bypass = cull_disable_reg || !s_axis_tuser[USER_HAS_SIZE]
                              || s_axis_tuser[USER_IN_CONTAIN];
        s1_next.side.tag    = s_axis_tdata[TAG_LSB +: TAG_BITS];
        s1_next.side.last   = s_axis_tlast;
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && s_axis_tvalid)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: top-left corner in Q.12 and bottom-right corner (plus size).
    // ------------------------------------------------------------------
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.ox   = (OW'(s1_reg.px) <<< 8) - (OW'(s1_reg.scr_x) <<< 4)
                       - $signed(OW'(s1_reg.anc_x));
        s2_next.oy   = (OW'(s1_reg.py) <<< 8) - (OW'(s1_reg.scr_y) <<< 4)
                       - $signed(OW'(s1_reg.anc_y));
        s2_next.ox2  = s2_next.ox + $signed(OW'(s1_reg.w) << 8);
        s2_next.oy2  = s2_next.oy + $signed(OW'(s1_reg.h) << 8);
        s2_next.side = s1_reg.side;
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the eight corner-by-coefficient products, one multiplier each.
    // ------------------------------------------------------------------
    s3_t s3_reg, s3_next;

    always_comb
    begin
        s3_next.ox_a  = s2_reg.ox * ma;
        s3_next.oy_c  = s2_reg.oy * mc;
        s3_next.ox_b  = s2_reg.ox * mb;
        s3_next.oy_d  = s2_reg.oy * md;
        s3_next.ox2_a = s2_reg.ox2 * ma;
        s3_next.oy2_c = s2_reg.oy2 * mc;
        s3_next.ox2_b = s2_reg.ox2 * mb;
        s3_next.oy2_d = s2_reg.oy2 * md;
        s3_next.side  = s2_reg.side;
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: mapped corners in Q.20 with the translation added.
    // ------------------------------------------------------------------
    s4_t s4_reg, s4_next;
    logic signed [TW-1:0] e_q20, f_q20;

    assign e_q20 = TW'(me) <<< SHIFT_Q20;
    assign f_q20 = TW'(mf) <<< SHIFT_Q20;

    always_comb
    begin
        s4_next.tx   = TW'(s3_reg.ox_a) + TW'(s3_reg.oy_c) + e_q20;
        s4_next.ty   = TW'(s3_reg.ox_b) + TW'(s3_reg.oy_d) + f_q20;
        s4_next.tw   = TW'(s3_reg.ox2_a) + TW'(s3_reg.oy2_c) + e_q20;
        s4_next.th   = TW'(s3_reg.ox2_b) + TW'(s3_reg.oy2_d) + f_q20;
        s4_next.side = s3_reg.side;
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: strict overlap test against the viewport in Q.20, into the
    // output register. A zero-sized viewport still keeps an object that strictly spans its position.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] bound_l, bound_r, bound_t, bound_b;
    logic                 overlap, keep_next;
    logic                 out_keep_reg, out_last_reg;
    logic [TAG_BITS-1:0]  out_tag_reg;

    assign bound_l = TW'(view_left) <<< SHIFT_Q20;
    assign bound_t = TW'(view_top) <<< SHIFT_Q20;
    assign bound_r = (TW'(view_left) + TW'($signed({1'b0, view_w}))) <<< SHIFT_Q20;
    assign bound_b = (TW'(view_top) + TW'($signed({1'b0, view_h}))) <<< SHIFT_Q20;

    assign overlap   = (s4_reg.tw > bound_l) && (s4_reg.tx < bound_r)
                       && (s4_reg.th > bound_t) && (s4_reg.ty < bound_b);
    assign keep_next = s4_reg.side.bypass || !det_nz_reg || overlap;

    always_ff @(posedge clk)
    begin
        if (ld_out && v4_reg)
        begin
            out_keep_reg <= keep_next;
            out_tag_reg  <= s4_reg.side.tag;
            out_last_reg <= s4_reg.side.last;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_keep_reg, out_tag_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "sprite_viewport_cull_unit_assert.svh"

    // Input is refused only when every stage holds an object.
    `SVC_ASSERT_IMPL(a_full_when_refused, !s_axis_tready, v1_reg && v2_reg && v3_reg && v4_reg && out_v_reg, "input stalled with a free stage")

    // Passing objects and a singular matrix always give a kept verdict.
    `SVC_ASSERT(a_bypass_keeps, (v4_reg && ld_out && (s4_reg.side.bypass || !det_nz_reg)) |=> m_axis_tdata[KEEP_BIT], "bypassed object was culled")

endmodule
